/* rtl/plst_pkg.sv */
`default_nettype none
package plst_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MERGE,
    S_HOLD
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic       ins;
    logic       rem;
    logic       sel;
    logic [4:0] pos;
  } cell_ctrl_t;

  localparam int unsigned GroupSize = 16;

endpackage
`default_nettype wire

/* rtl/positional_list_store.sv */
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// Input channel (in_valid/in_ready) carries func, position, value; output
// channel (out_valid/out_ready) carries data, status, count, one result word
// per input word, in order.
// func: insert at 0..count, remove at 0..count-1, read at 0..count-1.
// A refused operation changes nothing and returns data zero with status
// range or full; count is the entry count after the operation (low 5 bits).
// Steps: EXEC updates every cell at once and latches the addressed entry;
// MERGE folds those latches in groups of 16; HOLD folds the groups and
// loads the output register. No new word is taken until the last one has
// left HOLD, so words go through one at a time. in_ready is
// high while the sequencer is idle, also while a result still waits in the
// output register; a stalled receiver holds the next result in the last
// step and in_ready stays low until the output register frees.
// Reset empties the list and drops any pending result; no clearing pass.
`default_nettype none
module positional_list_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          func,
  input  wire logic [4:0]          position,
  input  wire logic signed [31:0]  value,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [31:0]       data,
  output logic [1:0]               status,
  output logic [4:0]               count
);

  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned NG = (CAPACITY + plst_pkg::GroupSize - 1) / plst_pkg::GroupSize;

  plst_pkg::state_t     state, state_next;
  plst_pkg::cell_ctrl_t ctrl;
  plst_pkg::status_t    st_r, st_next;

  logic [1:0]          func_r;
  logic [4:0]          pos_r;
  logic signed [31:0]  value_r;
  logic [LW-1:0]       length, length_next;
  logic [LW+4:0]       pos_ext, len_ext;

  logic signed [31:0]  ent [CAPACITY];
  logic signed [31:0]  tap [CAPACITY];
  logic signed [31:0]  part [NG];
  logic signed [31:0]  part_next [NG];
  logic signed [31:0]  fold;

  logic accept, load;

  assign accept   = in_valid && in_ready;
  assign load     = (state == plst_pkg::S_HOLD) && (!out_valid || out_ready);
  assign pos_ext  = {{LW{1'b0}}, pos_r};
  assign len_ext  = {5'd0, length};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      plst_pkg::S_IDLE:  if (accept) state_next = plst_pkg::S_EXEC;
      plst_pkg::S_EXEC:  state_next = plst_pkg::S_MERGE;
      plst_pkg::S_MERGE: state_next = plst_pkg::S_HOLD;
      plst_pkg::S_HOLD:  if (load) state_next = plst_pkg::S_IDLE;
      default:           state_next = plst_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    case (state)
      plst_pkg::S_IDLE: in_ready = 1'b1;
      default:          in_ready = 1'b0;
    endcase
  end

  // decode, checked against the length before the operation
  always_comb begin
    ctrl        = '0;
    ctrl.pos    = pos_r;
    st_next     = plst_pkg::ST_OK;
    length_next = length;
    if (state == plst_pkg::S_EXEC) begin
      case (func_r)
        plst_pkg::OP_INSERT: begin
          if (pos_ext > len_ext) begin
            st_next = plst_pkg::ST_RANGE;
          end else if (length == LW'(CAPACITY)) begin
            st_next = plst_pkg::ST_FULL;
          end else begin
            ctrl.ins    = 1'b1;
            length_next = length + LW'(1);
          end
        end
        plst_pkg::OP_REMOVE: begin
          if (pos_ext >= len_ext) begin
            st_next = plst_pkg::ST_RANGE;
          end else begin
            ctrl.rem    = 1'b1;
            ctrl.sel    = 1'b1;
            length_next = length - LW'(1);
          end
        end
        plst_pkg::OP_READ: begin
          if (pos_ext >= len_ext) begin
            st_next = plst_pkg::ST_RANGE;
          end else begin
            ctrl.sel = 1'b1;
          end
        end
        default: st_next = plst_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plst_pkg::S_IDLE;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= func;
      pos_r   <= position;
      value_r <= value;
    end
    if (state == plst_pkg::S_EXEC) begin
      st_r <= st_next;
    end
    if (load) begin
      data   <= fold;
      status <= st_r;
      count  <= len_ext[4:0];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = value_r;
    end else begin : g_mid
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = ent[i];
    end else begin : g_body
      assign right_w = ent[i+1];
    end
    plst_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left_w),
      .right (right_w),
      .value (value_r),
      .entry (ent[i]),
      .tap   (tap[i])
    );
  end

  // first fold: groups of cell taps
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_next[g] = 32'sd0;
      for (int k = 0; k < plst_pkg::GroupSize; k++) begin
        if (g * plst_pkg::GroupSize + k < CAPACITY) begin
          part_next[g] = part_next[g] | tap[g * plst_pkg::GroupSize + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == plst_pkg::S_MERGE) begin
      for (int g = 0; g < NG; g++) begin
        part[g] <= part_next[g];
      end
    end
  end

  always_comb begin
    fold = 32'sd0;
    for (int g = 0; g < NG; g++) begin
      fold = fold | part[g];
    end
  end

endmodule
`default_nettype wire

/* rtl/plst_cell.sv */
`default_nettype none
module plst_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                      clk,
  input  wire plst_pkg::cell_ctrl_t ctrl,
  input  wire logic signed [31:0]  left,
  input  wire logic signed [31:0]  right,
  input  wire logic signed [31:0]  value,
  output logic signed [31:0]       entry,
  output logic signed [31:0]       tap
);

  logic [31:0] pos_ext;
  logic        above;
  logic        here;

  assign pos_ext = {27'd0, ctrl.pos};
  assign above   = 32'(IDX) > pos_ext;
  assign here    = 32'(IDX) == pos_ext;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (above) begin
        entry <= left;
      end else if (here) begin
        entry <= value;
      end
    end else if (ctrl.rem) begin
      if (above || here) begin
        entry <= right;
      end
    end
  end

  // old contents of the addressed cell, zero elsewhere
  always_ff @(posedge clk) begin
    tap <= (ctrl.sel && here) ? entry : 32'sd0;
  end

endmodule
`default_nettype wire

/* rtl/plst_chk.sv */
`default_nettype none
module plst_chk #(
  parameter int unsigned CAPACITY = 16
) (
  input wire                      clk,
  input wire                      rst,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire logic [1:0]          func,
  input wire logic [4:0]          position,
  input wire logic signed [31:0]  value,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire logic signed [31:0]  data,
  input wire logic [1:0]          status,
  input wire logic [4:0]          count
);

  localparam logic [4:0] CapLow = 5'(CAPACITY);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status) && $stable(count))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != plst_pkg::ST_OK) |-> data == 32'sd0)
    else $error("refused operation returned data");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == plst_pkg::ST_FULL) |-> count == CapLow)
    else $error("full status with list not full");

endmodule

bind positional_list_store plst_chk #(.CAPACITY(CAPACITY)) u_plst_chk (.*);
`default_nettype wire

/* tb/plst_checker.sv */
`timescale 1ns / 1ps
module plst_checker #(
  parameter int unsigned Capacity = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire                in_ready,
  input  wire [1:0]          func,
  input  wire [4:0]          position,
  input  wire signed [31:0]  value,
  input  wire                out_valid,
  input  wire                out_ready,
  input  wire signed [31:0]  data,
  input  wire [1:0]          status,
  input  wire [4:0]          count,
  output int                 errors,
  output int                 pending,
  output int unsigned        list_len
);

  typedef struct packed {
    logic signed [31:0] data;
    plst_pkg::status_t  status;
    logic [4:0]         count;
  } answer_t;

  answer_t            answers_q[$];
  answer_t            oldest;
  logic signed [31:0] cells[Capacity];
  int unsigned        len;

  initial begin
    errors   = 0;
    pending  = 0;
    list_len = 0;
    len      = 0;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // apply one word to the shadow list and return the answer it should get
  function automatic answer_t list_op(logic [1:0] f, logic [4:0] p, logic signed [31:0] v);
    answer_t a;
    a.data   = '0;
    a.status = plst_pkg::ST_OK;
    case (f)
      plst_pkg::OP_INSERT: begin
        if (p > len) begin
          a.status = plst_pkg::ST_RANGE;
        end else if (len >= Capacity) begin
          a.status = plst_pkg::ST_FULL;
        end else begin
          for (int i = len; i > p; i--) cells[i] = cells[i-1];
          cells[p] = v;
          len++;
        end
      end
      plst_pkg::OP_REMOVE: begin
        if (p >= len) begin
          a.status = plst_pkg::ST_RANGE;
        end else begin
          a.data = cells[p];
          for (int i = p; i + 1 < len; i++) cells[i] = cells[i+1];
          len--;
        end
      end
      plst_pkg::OP_READ: begin
        if (p >= len) a.status = plst_pkg::ST_RANGE;
        else a.data = cells[p];
      end
      default: ;  // spare selector: no effect
    endcase
    a.count = 5'(len);
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      len = 0;
      answers_q.delete();
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (answers_q.size() == 0) begin
          report("result word with nothing pending");
        end else begin
          oldest = answers_q.pop_front();
          if (data !== oldest.data)
            report($sformatf("data %0d, want %0d", data, oldest.data));
          if (status !== oldest.status)
            report($sformatf("status %0d, want %0d", status, oldest.status));
          if (count !== oldest.count)
            report($sformatf("count %0d, want %0d", count, oldest.count));
        end
      end
      if (in_valid && in_ready === 1'b1)
        answers_q.push_back(list_op(func, position, value));
    end
    pending  = answers_q.size();
    list_len = len;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam int unsigned Capacity   = 16;
  localparam logic [1:0]  FuncSpare  = 2'd3;
  localparam int          CycleLimit = 400000;
  localparam int          PerPhase   = 210;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         func = '0;
  logic [4:0]         position = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] data;
  logic [1:0]         status;
  logic [4:0]         count;

  int          errors;
  int          pending;
  int unsigned list_len;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  bit          filling = 1'b1;

  positional_list_store #(.CAPACITY(Capacity)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .position(position), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .data(data), .status(status), .count(count)
  );

  plst_checker #(.Capacity(Capacity)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .position(position), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .data(data), .status(status), .count(count),
    .errors(errors), .pending(pending), .list_len(list_len)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic put_word(logic [1:0] f, logic [4:0] p, logic signed [31:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    position <= p;
    value    <= v;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_word();
    logic [1:0]         f;
    logic [4:0]         p;
    logic signed [31:0] v;
    int                 r;
    int unsigned        len;
    len = list_len;
    if (len == 0) filling = 1'b1;
    else if (len >= Capacity && $urandom_range(0, 3) == 0) filling = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 3) f = FuncSpare;
    else if (r < 33) f = plst_pkg::OP_READ;
    else if (r < (filling ? 78 : 48)) f = plst_pkg::OP_INSERT;
    else f = plst_pkg::OP_REMOVE;
    if ($urandom_range(0, 9) == 0) p = 5'($urandom_range(0, 31));
    else if (f == plst_pkg::OP_INSERT) p = 5'($urandom_range(0, len));
    else p = (len == 0) ? 5'd0 : 5'($urandom_range(0, len - 1));
    case ($urandom_range(0, 7))
      0: v = {1'b1, 31'd0};
      1: v = {1'b0, {31{1'b1}}};
      2: v = '0;
      3: v = '1;
      default: v = $urandom;
    endcase
    put_word(f, p, v);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list: everything but head insert is out of range
    put_word(plst_pkg::OP_READ, 5'd0, 32'sd5);
    put_word(plst_pkg::OP_REMOVE, 5'd0, 32'sd5);
    put_word(plst_pkg::OP_INSERT, 5'd1, 32'sd5);
    put_word(plst_pkg::OP_INSERT, 5'd0, {1'b1, 31'd0});
    put_word(plst_pkg::OP_INSERT, 5'd1, {1'b0, {31{1'b1}}});
    put_word(plst_pkg::OP_INSERT, 5'd0, -32'sd1);
    put_word(plst_pkg::OP_INSERT, 5'd1, 32'sd0);
    put_word(FuncSpare, 5'd2, 32'sd9);
    put_word(plst_pkg::OP_READ, 5'd3, 32'sd0);
    put_word(plst_pkg::OP_READ, 5'd4, 32'sd0);
    put_word(plst_pkg::OP_INSERT, 5'd31, 32'sd1);
    put_word(plst_pkg::OP_REMOVE, 5'd2, 32'sd0);
    while (list_len < Capacity)
      put_word(plst_pkg::OP_INSERT, 5'($urandom_range(0, list_len)), $urandom);
    // full list: bad position wins over full
    put_word(plst_pkg::OP_INSERT, 5'd3, 32'sd1);
    put_word(plst_pkg::OP_INSERT, 5'd17, 32'sd1);
    put_word(plst_pkg::OP_REMOVE, 5'd15, 32'sd0);
    put_word(plst_pkg::OP_READ, 5'd31, 32'sd0);
    in_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (PerPhase) random_word();
      in_valid <= 1'b0;
      drain();  // hold off until every word has come back
      @(negedge clk);
    end

    repeat (20) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* positional_list_store.f */
rtl/plst_pkg.sv
rtl/plst_cell.sv
rtl/positional_list_store.sv
rtl/plst_chk.sv
tb/plst_checker.sv
tb/tb.sv
